// ----- hdl/poslist_pkg.sv -----
package poslist_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ACTION_W  = 2;
  localparam int unsigned POS_W     = 5;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned CAPACITY  = 16;

  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE
  } cell_op_e;

  typedef struct packed {
    cell_op_e           op;
    logic [DATA_W-1:0]  value;
  } cell_ctrl_t;

endpackage

// ----- hdl/poslist_if.sv -----
interface poslist_req_if;
  logic                                      valid;
  logic                                      ready;
  logic        [poslist_pkg::ACTION_W-1:0]   action;
  logic        [poslist_pkg::POS_W-1:0]      position;
  logic signed [poslist_pkg::DATA_W-1:0]     value;

  modport source (output valid, action, position, value, input ready);
  modport sink   (input valid, action, position, value, output ready);
endinterface

interface poslist_rsp_if;
  logic                                      valid;
  logic                                      ready;
  logic        [poslist_pkg::STATUS_W-1:0]   status;
  logic signed [poslist_pkg::DATA_W-1:0]     data_out;
  logic        [poslist_pkg::LEN_W-1:0]      length_after;

  modport source (output valid, status, data_out, length_after, input ready);
  modport sink   (input valid, status, data_out, length_after, output ready);
endinterface

// ----- hdl/poslist_cell.sv -----
module poslist_cell #(
  parameter int unsigned CNT_W = 5,
  parameter int unsigned INDEX = 0
) (
  input  logic                             clk_i,
  input  poslist_pkg::cell_ctrl_t          ctrl_i,
  input  logic [CNT_W-1:0]                 pos_i,
  input  logic [poslist_pkg::DATA_W-1:0]   prev_i,
  input  logic [poslist_pkg::DATA_W-1:0]   next_i,
  output logic [poslist_pkg::DATA_W-1:0]   data_o,
  output logic [poslist_pkg::DATA_W-1:0]   sel_o
);

  localparam logic [CNT_W-1:0] Idx = CNT_W'(INDEX);

  logic [poslist_pkg::DATA_W-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    unique case (ctrl_i.op)
      poslist_pkg::CELL_INSERT: begin
        if (Idx == pos_i) begin
          data_d = ctrl_i.value;
        end else if (Idx > pos_i) begin
          data_d = prev_i;
        end
      end
      poslist_pkg::CELL_DELETE: begin
        if (Idx >= pos_i) begin
          data_d = next_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  // contributes to the read-out or-tree only when addressed
  assign sel_o  = (Idx == pos_i) ? data_q : '0;

endmodule

// ----- hdl/positional_list_insert_delete.sv -----
// Bounded ordered list of signed 32-bit values held in a row of CAPACITY cells.
// Every request (insert, delete or read at a position) is applied to all
// cells at once: they shift toward or away from the addressed position, and
// the result appears in the output register on the next cycle. One request
// per cycle is sustained as long as results are taken; while a result waits
// unread the input stalls, and a new request is taken in the cycle in which the
// waiting result is transferred. Read and delete data come from a select over
// all cells, so the cell count sets the depth of that path. Requests that are
// out of range or insert into a full list leave the list unchanged and report
// it in status.
module positional_list_insert_delete #(
  parameter int unsigned CAPACITY = poslist_pkg::CAPACITY
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  poslist_req_if.sink   req_i,
  poslist_rsp_if.source rsp_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned PosW = (CntW > poslist_pkg::POS_W) ? CntW : poslist_pkg::POS_W;
  localparam int unsigned DW   = poslist_pkg::DATA_W;

  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  logic [poslist_pkg::STATUS_W-1:0] status_q, status_d;
  logic [DW-1:0]   data_q, data_d;
  logic [poslist_pkg::LEN_W-1:0] len_q;

  logic            fire;
  logic [PosW-1:0] pos_ext, cnt_ext, cnt_next_ext;
  logic            pos_le_cnt, pos_lt_cnt, full;
  logic            ins_ok, del_ok;
  logic [CntW-1:0] cell_pos;
  poslist_pkg::cell_ctrl_t ctrl;

  logic [DW-1:0] cell_data [CAPACITY];
  logic [DW-1:0] cell_sel  [CAPACITY];
  logic [DW-1:0] rd_data;

  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign fire        = req_i.valid && req_i.ready;

  assign pos_ext    = PosW'(req_i.position);
  assign cnt_ext    = PosW'(count_q);
  assign pos_le_cnt = pos_ext <= cnt_ext;
  assign pos_lt_cnt = pos_ext < cnt_ext;
  assign full       = count_q == CntW'(CAPACITY);
  assign ins_ok     = (req_i.action == poslist_pkg::ACT_INSERT) && pos_le_cnt && !full;
  assign del_ok     = (req_i.action == poslist_pkg::ACT_DELETE) && pos_lt_cnt;
  // only used by the cells when the position is in range, so truncation is safe
  assign cell_pos   = pos_ext[CntW-1:0];

  always_comb begin
    ctrl.value = req_i.value;
    ctrl.op    = poslist_pkg::CELL_HOLD;
    if (fire && ins_ok) begin
      ctrl.op = poslist_pkg::CELL_INSERT;
    end else if (fire && del_ok) begin
      ctrl.op = poslist_pkg::CELL_DELETE;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DW-1:0] prev_w, next_w;
    if (i == 0) begin : g_first
      assign prev_w = cell_data[i];
    end else begin : g_mid
      assign prev_w = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_w = cell_data[i];
    end else begin : g_inner
      assign next_w = cell_data[i+1];
    end

    poslist_cell #(
      .CNT_W (CntW),
      .INDEX (i)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .pos_i  (cell_pos),
      .prev_i (prev_w),
      .next_i (next_w),
      .data_o (cell_data[i]),
      .sel_o  (cell_sel[i])
    );
  end

  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_data = rd_data | cell_sel[i];
    end
  end

  always_comb begin
    status_d = poslist_pkg::ST_RANGE;
    data_d   = '0;
    count_d  = count_q;
    unique case (req_i.action)
      poslist_pkg::ACT_INSERT: begin
        if (!pos_le_cnt) begin
          status_d = poslist_pkg::ST_RANGE;
        end else if (full) begin
          status_d = poslist_pkg::ST_FULL;
        end else begin
          status_d = poslist_pkg::ST_DONE;
          count_d  = count_q + CntW'(1);
        end
      end
      poslist_pkg::ACT_DELETE: begin
        if (pos_lt_cnt) begin
          status_d = poslist_pkg::ST_DONE;
          data_d   = rd_data;
          count_d  = count_q - CntW'(1);
        end
      end
      poslist_pkg::ACT_READ: begin
        if (pos_lt_cnt) begin
          status_d = poslist_pkg::ST_DONE;
          data_d   = rd_data;
        end
      end
      default: status_d = poslist_pkg::ST_RANGE;
    endcase
  end

  assign cnt_next_ext = PosW'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= status_d;
      data_q   <= data_d;
      len_q    <= cnt_next_ext[poslist_pkg::LEN_W-1:0];
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = status_q;
  assign rsp_o.data_out     = data_q;
  assign rsp_o.length_after = len_q;

endmodule
